// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// depends on nothing; files that assert pull it in by include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define DCGD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// same-cycle implication
`define DCGD_ASSERT_IMP(lbl, ante, cons, msg) \
    `DCGD_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define DCGD_ASSERT(lbl, prop, msg)
`define DCGD_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/dcgd_pkg.sv =====
// constants, tables and types of the day count to date converter
// depends on nothing
package dcgd_pkg;

    localparam int unsigned DAY_W   = 18;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 12;

    // day counts of the gregorian cycle, years counted from 1 march
    localparam logic [17:0] LAST_DAY     = 18'd146097;
    localparam logic [17:0] ERA_DAYS     = 18'd146097;
    localparam logic [17:0] CENT_DAYS    = 18'd36524;
    localparam logic [10:0] QUAD_DAYS    = 11'd1461;
    localparam logic [10:0] YEAR_DAYS    = 11'd365;
    // offset of 1 jan 1800 from 1 mar 1600
    localparam logic [17:0] EPOCH_OFFSET = 18'd72989;
    localparam logic [11:0] ERA_LO_YEAR  = 12'd1600;
    localparam logic [11:0] ERA_HI_YEAR  = 12'd2000;

    // floor(2^26 / 1461), low by at most one for remainders below 36525
    localparam int unsigned QUAD_SHIFT = 26;
    localparam logic [15:0] QUAD_RECIP = 16'd45933;

    // first day of each month, counted from 1 march
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef logic [8:0] t_doy;

    typedef struct packed {
        logic [DOM_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic               jan_feb;
    } t_month_res;

endpackage

// ===== rtl/dcgd_in_if.sv =====
// input channel of the converter: valid, ready and the day number
// depends on dcgd_pkg
interface dcgd_in_if;
    logic                         valid;
    logic                         ready;
    logic [dcgd_pkg::DAY_W-1:0]   day_number;

    modport source (output valid, output day_number, input ready);
    modport sink   (input valid, input day_number, output ready);
endinterface

// ===== rtl/dcgd_out_if.sv =====
// output channel of the converter: valid, ready and the date
// depends on dcgd_pkg
interface dcgd_out_if;
    logic                           valid;
    logic                           ready;
    logic [dcgd_pkg::DOM_W-1:0]     day_of_month;
    logic [dcgd_pkg::MONTH_W-1:0]   month_number;
    logic [dcgd_pkg::YEAR_W-1:0]    year_number;
    logic                           out_of_range;

    modport source (output valid, output day_of_month, output month_number,
                    output year_number, output out_of_range, input ready);
    modport sink   (input valid, input day_of_month, input month_number,
                    input year_number, input out_of_range, output ready);
endinterface

// ===== rtl/dcgd_month.sv =====
// splits a day of a march-based year into month and day of month
// depends on dcgd_pkg
module dcgd_month (
    input  dcgd_pkg::t_doy     i_doy,
    output dcgd_pkg::t_month_res o_res
);

    logic [3:0] mp;
    logic [8:0] start;
    logic [8:0] offs;

    // month index is the number of month starts after the first that lie at or below doy
    always_comb begin
        mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (i_doy >= dcgd_pkg::MONTH_START[k]) begin
                mp = mp + 4'd1;
            end
        end
    end

    assign start = dcgd_pkg::MONTH_START[mp];
    assign offs  = i_doy - start;

    always_comb begin
        o_res.day     = offs[dcgd_pkg::DOM_W-1:0] + 5'd1;
        o_res.jan_feb = (mp >= 4'd10);
        o_res.month   = (mp >= 4'd10) ? (mp - 4'd9) : (mp + 4'd3);
    end

endmodule

// ===== rtl/day_count_to_gregorian_date.sv =====
// Day number to Gregorian date converter. Day number 1 is 1 January 1800 and
// 146097 is 31 December 2199; anything else gives out_of_range with a zero
// date. The conversion is a six-stage pipeline: the day is moved onto a
// 400-year cycle that begins on 1 March, split into century, four-year block,
// year and day of year, and the day of year into month and day. The four-year
// split divides by 1461 through a multiply by its reciprocal and a one-step
// correction; every other split is a handful of compares against constants.
// One transaction enters per clock while the output does not stall, and its
// result leaves from the stage 6 register. All stages advance together whenever
// the output register is empty or being taken, so a stall at the output holds
// the whole pipe and i_day.ready follows o_date.ready in the same cycle.
// depends on dcgd_pkg, dcgd_in_if, dcgd_out_if, dcgd_month, assert_macros.svh
`include "assert_macros.svh"

module day_count_to_gregorian_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcgd_in_if.sink     i_day,
    dcgd_out_if.source  o_date
);

    // pipeline advance
    logic en;

    // stage valid bits
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_vld6;

    // stage 1: day in cycle, era select, range flag
    logic [17:0] r_t_1;
    logic        r_era_1, r_oor_1;
    // stage 2: century and day within century
    logic [1:0]  r_c_2;
    logic [15:0] r_r1_2;
    logic        r_era_2, r_oor_2;
    // stage 3: rough four-year block index
    logic [4:0]  r_q0_3;
    logic [15:0] r_r1_3;
    logic [1:0]  r_c_3;
    logic        r_era_3, r_oor_3;
    // stage 4: exact block index and day within block
    logic [4:0]  r_q_4;
    logic [10:0] r_r2_4;
    logic [1:0]  r_c_4;
    logic        r_era_4, r_oor_4;
    // stage 5: year of cycle and day of year
    logic [8:0]  r_yoe_5;
    dcgd_pkg::t_doy r_doy_5;
    logic        r_era_5, r_oor_5;
    // stage 6: output register
    logic [4:0]  r_dom_6;
    logic [3:0]  r_mon_6;
    logic [11:0] r_year_6;
    logic        r_oor_6;

    // next values
    logic        n_oor_1;
    logic [18:0] n_traw;
    logic [17:0] n_t_1;
    logic        n_era_1;
    logic [1:0]  n_c_2;
    logic [17:0] n_cbase;
    logic [15:0] n_r1_2;
    logic [31:0] n_prod;
    logic [15:0] n_qbase;
    logic [15:0] n_rem;
    logic [4:0]  n_q_4;
    logic [10:0] n_r2_4;
    logic [1:0]  n_yy;
    logic [10:0] n_ybase;
    logic [10:0] n_doy_w;
    logic [8:0]  n_yoe_5;
    dcgd_pkg::t_month_res n_mres;
    logic [11:0] n_year_6;

    assign en          = !r_vld6 || o_date.ready;
    assign i_day.ready = en;

    // stage 1: range check, shift onto the cycle starting 1 mar 1600
    always_comb begin
        n_oor_1 = (i_day.day_number == '0) || (i_day.day_number > dcgd_pkg::LAST_DAY);
        n_traw  = {1'b0, i_day.day_number - 18'd1} + {1'b0, dcgd_pkg::EPOCH_OFFSET};
        n_era_1 = (n_traw >= {1'b0, dcgd_pkg::ERA_DAYS});
        if (n_oor_1) begin
            n_t_1   = '0;
            n_era_1 = 1'b0;
        end else if (n_era_1) begin
            n_t_1 = 18'(n_traw - {1'b0, dcgd_pkg::ERA_DAYS});
        end else begin
            n_t_1 = n_traw[17:0];
        end
    end

    // stage 2: century, the last one holds the extra leap day
    always_comb begin
        n_c_2 = 2'd0;
        if (r_t_1 >= dcgd_pkg::CENT_DAYS) n_c_2 = 2'd1;
        if (r_t_1 >= 18'(2 * dcgd_pkg::CENT_DAYS)) n_c_2 = 2'd2;
        if (r_t_1 >= 18'(3 * dcgd_pkg::CENT_DAYS)) n_c_2 = 2'd3;
        unique case (n_c_2)
            2'd0:    n_cbase = '0;
            2'd1:    n_cbase = dcgd_pkg::CENT_DAYS;
            2'd2:    n_cbase = 18'(2 * dcgd_pkg::CENT_DAYS);
            default: n_cbase = 18'(3 * dcgd_pkg::CENT_DAYS);
        endcase
        n_r1_2 = 16'(r_t_1 - n_cbase);
    end

    // stage 3: reciprocal multiply for the block index
    assign n_prod = r_r1_2 * dcgd_pkg::QUAD_RECIP;

    // stage 4: remainder and one-step correction
    always_comb begin
        n_qbase = {11'd0, r_q0_3} * {5'd0, dcgd_pkg::QUAD_DAYS};
        n_rem   = r_r1_3 - n_qbase;
        if (n_rem >= {5'd0, dcgd_pkg::QUAD_DAYS}) begin
            n_q_4  = r_q0_3 + 5'd1;
            n_r2_4 = 11'(n_rem - {5'd0, dcgd_pkg::QUAD_DAYS});
        end else begin
            n_q_4  = r_q0_3;
            n_r2_4 = n_rem[10:0];
        end
    end

    // stage 5: year within block, the fourth year keeps the leap day
    always_comb begin
        n_yy = 2'd0;
        if (r_r2_4 >= dcgd_pkg::YEAR_DAYS) n_yy = 2'd1;
        if (r_r2_4 >= 11'(2 * dcgd_pkg::YEAR_DAYS)) n_yy = 2'd2;
        if (r_r2_4 >= 11'(3 * dcgd_pkg::YEAR_DAYS)) n_yy = 2'd3;
        unique case (n_yy)
            2'd0:    n_ybase = '0;
            2'd1:    n_ybase = dcgd_pkg::YEAR_DAYS;
            2'd2:    n_ybase = 11'(2 * dcgd_pkg::YEAR_DAYS);
            default: n_ybase = 11'(3 * dcgd_pkg::YEAR_DAYS);
        endcase
        n_doy_w = r_r2_4 - n_ybase;
        n_yoe_5 = ({7'd0, r_c_4} * 9'd100) + {2'd0, r_q_4, 2'd0} + {7'd0, n_yy};
    end

    // stage 6: month split, january and february belong to the next year
    dcgd_month u_month (
        .i_doy (r_doy_5),
        .o_res (n_mres)
    );

    always_comb begin
        n_year_6 = (r_era_5 ? dcgd_pkg::ERA_HI_YEAR : dcgd_pkg::ERA_LO_YEAR)
                 + {3'd0, r_yoe_5} + {11'd0, n_mres.jan_feb};
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_day.valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_1   <= n_t_1;
            r_era_1 <= n_era_1;
            r_oor_1 <= n_oor_1;

            r_c_2   <= n_c_2;
            r_r1_2  <= n_r1_2;
            r_era_2 <= r_era_1;
            r_oor_2 <= r_oor_1;

            r_q0_3  <= n_prod[dcgd_pkg::QUAD_SHIFT +: 5];
            r_r1_3  <= r_r1_2;
            r_c_3   <= r_c_2;
            r_era_3 <= r_era_2;
            r_oor_3 <= r_oor_2;

            r_q_4   <= n_q_4;
            r_r2_4  <= n_r2_4;
            r_c_4   <= r_c_3;
            r_era_4 <= r_era_3;
            r_oor_4 <= r_oor_3;

            r_yoe_5 <= n_yoe_5;
            r_doy_5 <= n_doy_w[8:0];
            r_era_5 <= r_era_4;
            r_oor_5 <= r_oor_4;

            r_oor_6 <= r_oor_5;
            if (r_oor_5) begin
                r_dom_6  <= '0;
                r_mon_6  <= '0;
                r_year_6 <= '0;
            end else begin
                r_dom_6  <= n_mres.day;
                r_mon_6  <= n_mres.month;
                r_year_6 <= n_year_6;
            end
        end
    end

    assign o_date.valid        = r_vld6;
    assign o_date.day_of_month = r_dom_6;
    assign o_date.month_number = r_mon_6;
    assign o_date.year_number  = r_year_6;
    assign o_date.out_of_range = r_oor_6;

    // checks
    `DCGD_ASSERT_IMP(a_oor_zero, o_date.valid && o_date.out_of_range,
        o_date.day_of_month == 5'd0 && o_date.month_number == 4'd0
            && o_date.year_number == 12'd0,
        "out of range result carries a date")
    `DCGD_ASSERT_IMP(a_date_span, o_date.valid && !o_date.out_of_range,
        o_date.day_of_month >= 5'd1 && o_date.month_number >= 4'd1
            && o_date.month_number <= 4'd12 && o_date.year_number >= 12'd1800
            && o_date.year_number <= 12'd2199,
        "date outside the supported span")
    `DCGD_ASSERT_IMP(a_cent_rem, r_vld2, r_r1_2 <= 16'd36524,
        "day within century too large")
    `DCGD_ASSERT_IMP(a_quad_rem, r_vld4, r_r2_4 < dcgd_pkg::QUAD_DAYS,
        "block division not corrected")
    `DCGD_ASSERT(a_ready_free, !o_date.valid |-> i_day.ready,
        "input held off with an empty output register")

endmodule

// ===== tb/day_count_to_gregorian_date_tb.sv =====
// self-checking testbench of the day count to gregorian date converter
// depends on dcgd_pkg, dcgd_in_if, dcgd_out_if and day_count_to_gregorian_date
module day_count_to_gregorian_date_tb;

    localparam int unsigned EPOCH_YEAR   = 1800;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned RANDOM_DAYS  = 1130;
    localparam int unsigned QUIET_TAIL   = 150;   // last transactions run without idling
    localparam int unsigned HOLD_AT      = 300;   // result count that starts the long hold-off
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned DRAIN_AT     = 700;   // sender waits for all dates after this one
    localparam int unsigned SETTLE       = 16;    // pipe depth plus margin
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [dcgd_pkg::DOM_W-1:0]   day;
        logic [dcgd_pkg::MONTH_W-1:0] month;
        logic [dcgd_pkg::YEAR_W-1:0]  year;
        logic                         oor;
    } t_date;

    logic clk;
    logic rst_n;

    dcgd_in_if  day_if ();
    dcgd_out_if date_if ();

    day_count_to_gregorian_date dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_day   (day_if),
        .o_date  (date_if)
    );

    logic [dcgd_pkg::DAY_W-1:0] pending_days [$];
    t_date            expected_dates [$];
    int unsigned      total_days;
    int unsigned      days_sent;
    int unsigned      dates_seen;
    int unsigned      fail_count;
    int unsigned      stall_run;
    int unsigned      send_gap;
    int unsigned      send_idle_pct;
    int unsigned      recv_gap;
    int unsigned      recv_idle_pct;
    int unsigned      hold_left;
    bit               draining;

    function automatic bit is_leap(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned days_in_year(input int unsigned yr);
        return is_leap(yr) ? 366 : 365;
    endfunction

    // mo counts from 0 for january
    function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
        return MONTH_DAYS[mo] + ((mo == 1 && is_leap(yr)) ? 1 : 0);
    endfunction

    // expected date of one day number
    function automatic t_date convert_day(input logic [dcgd_pkg::DAY_W-1:0] dn);
        t_date       res;
        int unsigned offset;
        int unsigned yr;
        int unsigned mo;
        res = '0;
        if (dn == '0 || dn > dcgd_pkg::LAST_DAY) begin
            res.oor = 1'b1;
            return res;
        end
        offset = dn - 1;
        yr     = EPOCH_YEAR;
        while (offset >= days_in_year(yr)) begin
            offset -= days_in_year(yr);
            yr++;
        end
        mo = 0;
        while (mo < 11 && offset >= days_in_month(mo, yr)) begin
            offset -= days_in_month(mo, yr);
            mo++;
        end
        res.day   = dcgd_pkg::DOM_W'(offset + 1);
        res.month = dcgd_pkg::MONTH_W'(mo + 1);
        res.year  = dcgd_pkg::YEAR_W'(yr);
        return res;
    endfunction

    // day number of a calendar date, month and day counted from 1
    function automatic logic [dcgd_pkg::DAY_W-1:0] day_number_of(input int unsigned yr,
                                                                 input int unsigned mo,
                                                                 input int unsigned dd);
        int unsigned n;
        n = dd;
        for (int unsigned y = EPOCH_YEAR; y < yr; y++) n += days_in_year(y);
        for (int unsigned m = 0; m + 1 < mo; m++) n += days_in_month(m, yr);
        return dcgd_pkg::DAY_W'(n);
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sender: offers queued day numbers, idles in bursts
    always @(posedge clk) begin : drive_days
        logic                       offer;
        logic [dcgd_pkg::DAY_W-1:0] next_day;
        if (!rst_n) begin
            day_if.valid      <= 1'b0;
            day_if.day_number <= '0;
        end else begin
            offer    = day_if.valid;
            next_day = day_if.day_number;
            if (day_if.valid && day_if.ready) begin
                expected_dates.push_back(convert_day(day_if.day_number));
                days_sent++;
                offer = 1'b0;
                if (days_sent % 100 == 0) send_idle_pct = pick_idle_pct();
                if (days_sent == DRAIN_AT)
                    draining = 1'b1;
                else if (pending_days.size() >= QUIET_TAIL &&
                         $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, 8);
            end
            if (!offer) begin
                if (draining && expected_dates.size() == 0) draining = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!draining && pending_days.size() > 0) begin
                    offer    = 1'b1;
                    next_day = pending_days.pop_front();
                end
            end
            day_if.valid      <= offer;
            day_if.day_number <= next_day;
        end
    end

    // receiver: checks each date against the oldest prediction
    always @(posedge clk) begin : check_dates
        logic  take;
        t_date got;
        t_date want;
        if (!rst_n) begin
            date_if.ready <= 1'b0;
        end else begin
            if (date_if.valid && date_if.ready) begin
                got.day   = date_if.day_of_month;
                got.month = date_if.month_number;
                got.year  = date_if.year_number;
                got.oor   = date_if.out_of_range;
                dates_seen++;
                if (dates_seen % 100 == 0) recv_idle_pct = pick_idle_pct();
                if (expected_dates.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected date %0d-%0d-%0d oor %0b",
                                 got.year, got.month, got.day, got.oor);
                end else begin
                    want = expected_dates.pop_front();
                    if (got.day !== want.day || got.month !== want.month ||
                        got.year !== want.year || got.oor !== want.oor) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"date %0d: expected %0d-%0d-%0d oor %0b,",
                                      " got %0d-%0d-%0d oor %0b"},
                                     dates_seen, want.year, want.month, want.day, want.oor,
                                     got.year, got.month, got.day, got.oor);
                    end
                end
                if (dates_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                take = 1'b0;
            end else if (dates_seen + QUIET_TAIL < total_days &&
                         $urandom_range(0, 99) < recv_idle_pct / 3) begin
                recv_gap = $urandom_range(1, 8) - 1;
                take     = 1'b0;
            end else begin
                take = 1'b1;
            end
            date_if.ready <= take;
        end
    end

    // cycles in a row with no transaction on either side
    always @(posedge clk) begin
        if ((day_if.valid && day_if.ready) || (date_if.valid && date_if.ready))
            stall_run <= 0;
        else
            stall_run <= stall_run + 1;
    end

    initial begin : watchdog
        while (stall_run < STALL_LIMIT) @(posedge clk);
        $display("FAIL day_count_to_gregorian_date");
        $finish;
    end

    initial begin : run_test
        int unsigned yr;
        int unsigned mo;
        int unsigned pick;
        rst_n             = 1'b0;
        day_if.valid      = 1'b0;
        day_if.day_number = '0;
        date_if.ready     = 1'b0;
        days_sent         = 0;
        dates_seen        = 0;
        fail_count        = 0;
        stall_run         = 0;
        send_gap          = 0;
        recv_gap          = 0;
        hold_left         = 0;
        draining          = 1'b0;
        send_idle_pct     = pick_idle_pct();
        recv_idle_pct     = pick_idle_pct();

        // out of range at both ends, epoch and last day, and the days either side of 2^17
        pending_days.push_back('0);
        pending_days.push_back(dcgd_pkg::DAY_W'(1));
        pending_days.push_back(dcgd_pkg::DAY_W'(146097));
        pending_days.push_back(dcgd_pkg::DAY_W'(146098));
        pending_days.push_back('1);
        pending_days.push_back(dcgd_pkg::DAY_W'(131071));
        pending_days.push_back(dcgd_pkg::DAY_W'(131072));
        // century year without leap day, then ordinary and 400-year leap years
        pending_days.push_back(day_number_of(1800, 2, 28));
        pending_days.push_back(day_number_of(1800, 3, 1));
        pending_days.push_back(day_number_of(1800, 12, 31));
        pending_days.push_back(day_number_of(1801, 1, 1));
        pending_days.push_back(day_number_of(1804, 2, 29));
        pending_days.push_back(day_number_of(1804, 3, 1));
        pending_days.push_back(day_number_of(1804, 12, 31));
        pending_days.push_back(day_number_of(1900, 2, 28));
        pending_days.push_back(day_number_of(1900, 3, 1));
        pending_days.push_back(day_number_of(2000, 2, 29));
        pending_days.push_back(day_number_of(2000, 3, 1));
        pending_days.push_back(day_number_of(2000, 12, 31));
        pending_days.push_back(day_number_of(2100, 3, 1));
        pending_days.push_back(day_number_of(2199, 12, 31));

        for (int unsigned i = 0; i < RANDOM_DAYS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                pending_days.push_back(dcgd_pkg::DAY_W'($urandom_range(1, 146097)));
            end else if (pick < 75) begin
                // year and month boundaries
                yr = $urandom_range(EPOCH_YEAR, 2199);
                case ($urandom_range(0, 5))
                    0: pending_days.push_back(day_number_of(yr, 1, 1));
                    1: pending_days.push_back(day_number_of(yr, 12, 31));
                    2: pending_days.push_back(day_number_of(yr, 2, 28));
                    3: pending_days.push_back(day_number_of(yr, 2, days_in_month(1, yr)));
                    4: pending_days.push_back(day_number_of(yr, 3, 1));
                    default: begin
                        mo = $urandom_range(1, 12);
                        pending_days.push_back(day_number_of(yr, mo, days_in_month(mo - 1, yr)));
                    end
                endcase
            end else if (pick < 90) begin
                pending_days.push_back(dcgd_pkg::DAY_W'($urandom_range(0, 262143)));
            end else if (pick < 95) begin
                pending_days.push_back(dcgd_pkg::DAY_W'($urandom_range(146090, 146105)));
            end else begin
                pending_days.push_back(dcgd_pkg::DAY_W'($urandom_range(0, 40)));
            end
        end
        total_days = pending_days.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_days.size() != 0 || day_if.valid || expected_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (expected_dates.size() != 0) fail_count++;

        if (fail_count == 0)
            $display("PASS day_count_to_gregorian_date");
        else
            $display("FAIL day_count_to_gregorian_date");
        $finish;
    end
endmodule
